FILE: sv/tcv_pkg.sv
// Package: shared types and constants for the cwnd validation engine.
package tcv_pkg;

    localparam logic [2:0] OP_ACK      = 3'd0;
    localparam logic [2:0] OP_TX_START = 3'd1;
    localparam logic [2:0] OP_CWR      = 3'd2;
    localparam logic [2:0] OP_LOSS     = 3'd3;
    localparam logic [2:0] OP_SLOW_ACK = 3'd4;
    localparam logic [2:0] OP_SS_QUERY = 3'd5;

    localparam logic [1:0] REG_MIN_PERIOD = 2'd0;
    localparam logic [1:0] REG_CLOSEDOWN  = 2'd1;
    localparam logic [1:0] REG_INIT_CWND  = 2'd2;
    localparam logic [1:0] REG_RESTART    = 2'd3;

    localparam logic [5:0] CLOSEDOWN_CAP = 6'd40;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] now_ticks;
        logic [31:0] acked_seq;
        logic [31:0] next_seq;
        logic [31:0] srtt_ticks;
        logic [31:0] cwnd_in;
        logic [31:0] ssthresh_in;
        logic [15:0] mss;
        logic [31:0] in_flight;
        logic [31:0] retx_count;
        logic        cwnd_limited;
    } t_in;

    typedef struct packed {
        logic [31:0] cwnd_out;
        logic [31:0] ssthresh_out;
        logic [31:0] pipeack_out;
        logic        pipeack_defined;
        logic        validated;
        logic        allow_increase;
        logic        in_recovery;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture item, compute period on ack
        logic ack_upd;   // sample/bin update
        logic walk_init;
        logic walk_step;
        logic ack_valid; // validity decision on ack
        logic cd_init;   // start closedown division
        logic div_step;  // one quotient bit
        logic cd_apply;  // advance stamp, set step count
        logic cd_step;   // one halving
        logic cwr_init;  // start pipeACK/mss division
        logic cwr_fin;
        logic slow_fin;
        logic loss;
        logic ssq;
        logic out_load;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic walk_done;
        logic div_done;
        logic cd_needed;
        logic cd_done;
        logic nonvalid;
        logic slow_go;
    } t_sts;

endpackage

FILE: sv/tcp_cwnd_validation_engine.sv
// Top level of the TCP congestion window validation engine.
// Input channel: i_in_valid / o_in_stall carry one event transaction (i_in_data).
// Output channel: o_out_valid / i_out_stall carry one result transaction per event.
// Config channel: i_cfg_valid / o_cfg_ready with a register index and data;
// index 0 min sample period, 1 closedown interval, 2 init cwnd, 3 restart window.
// Write configuration only while no event is in progress.
// An event passes a dispatch state, its steps and the result state. An ack
// updates the filter, walks 1 to BINS bins, makes the validity decision and
// checks closedown if nonvalid; tx_start checks closedown. Closedown runs a
// bit-serial divide, one apply step and one step per cwnd halving (at most 40).
// Active recovery entry and complete_cwr run the pipeACK/mss divide; loss,
// ssthresh query, unused codes and inactive complete_cwr / slow ack go straight
// to the result. One event is processed at a time; the next event is accepted
// at the earliest on the edge that takes the result.
// The result register holds while the receiver stalls and input stays stalled.
// Synchronous active-low reset loads register defaults, clears the filter
// and sets the validated flag.
module tcp_cwnd_validation_engine #(
    parameter int BINS = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  tcv_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output tcv_pkg::t_out  o_out_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [1:0]     i_cfg_index,
    input  logic [31:0]    i_cfg_data
);
    import tcv_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    tcv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_op        (i_in_data.operation),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    tcv_dp #(.BINS(BINS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_in_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_idx  (i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_out      (o_out_data)
    );

endmodule

FILE: sv/tcv_ctrl.sv
// Controller: sequences the steps for one event.
module tcv_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  logic [2:0]    i_op,
    input  tcv_pkg::t_sts i_sts,
    output tcv_pkg::t_cmd o_cmd
);
    import tcv_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0, S_ACK = 4'd1, S_WALK = 4'd2, S_VAL = 4'd3,
                           S_CDCHK = 4'd4, S_CDDIV = 4'd5, S_CDAPP = 4'd6,
                           S_CDSTEP = 4'd7, S_MDIV = 4'd8, S_FIN = 4'd9,
                           S_DISPATCH = 4'd10;

    logic [3:0] r_state, n_state;
    logic [2:0] r_op;
    logic       r_out_valid, n_out_valid;

    assign o_in_stall  = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && !o_in_stall) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (r_op)
                    OP_ACK: n_state = S_ACK;
                    OP_TX_START: n_state = S_CDCHK;
                    OP_CWR: begin
                        if (i_sts.nonvalid) begin
                            o_cmd.cwr_init = 1'b1;
                            n_state = S_MDIV;
                        end else begin
                            n_state = S_FIN;
                        end
                    end
                    OP_SLOW_ACK: begin
                        if (i_sts.slow_go) begin
                            o_cmd.cwr_init = 1'b1;
                            n_state = S_MDIV;
                        end else begin
                            n_state = S_FIN;
                        end
                    end
                    OP_LOSS: begin
                        o_cmd.loss = 1'b1;
                        n_state = S_FIN;
                    end
                    OP_SS_QUERY: begin
                        o_cmd.ssq = 1'b1;
                        n_state = S_FIN;
                    end
                    default: n_state = S_FIN;
                endcase
            end
            S_ACK: begin
                o_cmd.ack_upd = 1'b1;
                n_state = S_WALK;
            end
            S_WALK: begin
                if (i_sts.walk_done) begin
                    n_state = S_VAL;
                end else begin
                    o_cmd.walk_step = 1'b1;
                end
            end
            S_VAL: begin
                o_cmd.ack_valid = 1'b1;
                n_state = S_CDCHK;
            end
            S_CDCHK: begin
                if ((r_op == OP_TX_START || i_sts.nonvalid) && i_sts.cd_needed) begin
                    o_cmd.cd_init = 1'b1;
                    n_state = S_CDDIV;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_CDDIV: begin
                if (i_sts.div_done) begin
                    n_state = S_CDAPP;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_CDAPP: begin
                o_cmd.cd_apply = 1'b1;
                n_state = S_CDSTEP;
            end
            S_CDSTEP: begin
                if (i_sts.cd_done) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.cd_step = 1'b1;
                end
            end
            S_MDIV: begin
                if (i_sts.div_done) begin
                    if (r_op == OP_CWR) begin
                        o_cmd.cwr_fin = 1'b1;
                    end else begin
                        o_cmd.slow_fin = 1'b1;
                    end
                    n_state = S_FIN;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_FIN: begin
                o_cmd.out_load = 1'b1;
                n_out_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_ACK) o_cmd.walk_init = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        if (o_cmd.load) r_op <= i_op;
    end

endmodule

FILE: sv/tcv_dp.sv
// Datapath: filter bins, windows, divider and closedown unit.
module tcv_dp #(
    parameter int BINS = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tcv_pkg::t_in  i_item,
    input  tcv_pkg::t_cmd i_cmd,
    output tcv_pkg::t_sts o_sts,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [31:0]   i_cfg_data,
    output tcv_pkg::t_out o_out
);
    import tcv_pkg::*;

    localparam int HW = (BINS > 1) ? $clog2(BINS) : 1;
    localparam int CW = $clog2(BINS + 1);

    logic [15:0] r_min_period, r_init_cwnd, r_restart;
    logic [31:0] r_cd_iv;

    t_in         r_it;
    logic [31:0] r_cwnd, r_ss;
    logic [31:0] r_bins [BINS];
    logic [31:0] r_stamps [BINS];
    logic [BINS-1:0] r_live;
    logic [HW-1:0] r_head, r_wk;
    logic [CW-1:0] r_wcnt;
    logic        r_wdone, r_found;
    logic [31:0] r_best, r_pa;
    logic        r_pa_live, r_valid, r_recov, r_allow;
    logic [31:0] r_last_ack, r_last_next, r_vstamp, r_period, r_pinfl, r_pretr;
    // shared restoring divider
    logic [31:0] r_dnum, r_dq, r_ddiv;
    logic [31:0] r_drem;
    logic [5:0]  r_dcnt;
    logic [5:0]  r_cdn;
    t_out        r_out;

    function automatic logic [HW-1:0] nxt(input logic [HW-1:0] x);
        return (32'(x) + 1 >= BINS) ? '0 : HW'(32'(x) + 1);
    endfunction
    function automatic logic [HW-1:0] prv(input logic [HW-1:0] x);
        return (x == '0) ? HW'(BINS - 1) : HW'(32'(x) - 1);
    endfunction

    // max(3*srtt saturated, minimum period)
    function automatic logic [31:0] period_of(input logic [31:0] srtt,
                                              input logic [15:0] min_p);
        logic [33:0] p;
        p = 34'(srtt) + {1'b0, srtt, 1'b0};
        if (p > 34'hFFFFFFFF) p = 34'hFFFFFFFF;
        if (p[31:0] < 32'(min_p)) return 32'(min_p);
        return p[31:0];
    endfunction

    logic [31:0] iv, diff, smp, base, gone, w, rem_base, q_c, h_c;
    logic [33:0] q3;
    logic        expired;
    logic [63:0] cwmss;
    always_comb begin
        iv   = (r_cd_iv == '0) ? 32'd1 : r_cd_iv;
        diff = r_it.now_ticks - r_vstamp;
        smp  = r_it.acked_seq - r_last_ack;
        expired = (r_it.now_ticks >= r_period) &&
                  (r_stamps[r_wk] < r_it.now_ticks - r_period);
        cwmss = r_it.cwnd_in * 64'(r_it.mss);
        base = (r_dq > r_pinfl) ? r_dq : r_pinfl;
        gone = r_it.retx_count - r_pretr;
        rem_base = (base > gone) ? base - gone : 32'd0;
        w = rem_base >> 1;
        if (w < 32'(r_restart)) w = 32'(r_restart);
        q3  = (34'(r_cwnd) + {1'b0, r_cwnd, 1'b0}) >> 2;
        h_c = r_cwnd >> 1;
        if (h_c < 32'(r_init_cwnd)) h_c = 32'(r_init_cwnd);
        q_c = q3[31:0];
    end

    logic [32:0] dtrial;
    assign dtrial = {r_drem, r_dnum[31]} - {1'b0, r_ddiv};

    assign o_sts.walk_done = r_wdone;
    assign o_sts.div_done  = (r_dcnt == 6'd32);
    assign o_sts.cd_needed = diff > iv;
    assign o_sts.cd_done   = (r_cdn == '0);
    assign o_sts.nonvalid  = !r_valid;
    assign o_sts.slow_go   = !r_valid && !r_recov;
    assign o_out = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_period <= 16'd1000;
            r_cd_iv      <= 32'd75000000;
            r_init_cwnd  <= 16'd10;
            r_restart    <= 16'd1;
            r_live       <= '0;
            r_head       <= '0;
            r_pa_live    <= 1'b0;
            r_valid      <= 1'b1;
            r_recov      <= 1'b0;
            r_last_ack   <= '0;
            r_last_next  <= '0;
            r_vstamp     <= '0;
            r_period     <= 32'd1000;
            r_pinfl      <= '0;
            r_pretr      <= '0;
            for (int i = 0; i < BINS; i++) r_stamps[i] <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MIN_PERIOD: r_min_period <= i_cfg_data[15:0];
                    REG_CLOSEDOWN:  r_cd_iv      <= i_cfg_data;
                    REG_INIT_CWND:  r_init_cwnd  <= i_cfg_data[15:0];
                    REG_RESTART:    r_restart    <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_it    <= i_item;
                r_cwnd  <= i_item.cwnd_in;
                r_ss    <= i_item.ssthresh_in;
                r_allow <= 1'b0;
                if (i_item.operation == OP_ACK) begin
                    r_pinfl  <= i_item.in_flight;
                    r_pretr  <= i_item.retx_count;
                    r_period <= period_of(i_item.srtt_ticks, r_min_period);
                end
            end
            if (i_cmd.ack_upd && r_it.acked_seq >= r_last_next) begin
                r_last_ack  <= r_it.acked_seq;
                r_last_next <= r_it.next_seq;
                if (33'(r_it.now_ticks) > 33'(r_stamps[r_head]) + 33'(r_period >> 2)) begin
                    r_head <= nxt(r_head);
                    r_bins[nxt(r_head)]   <= smp;
                    r_live[nxt(r_head)]   <= 1'b1;
                    r_stamps[nxt(r_head)] <= r_it.now_ticks;
                end else if (!r_live[r_head] || smp > r_bins[r_head]) begin
                    r_bins[r_head] <= smp;
                    r_live[r_head] <= 1'b1;
                end
            end
            if (i_cmd.walk_init) begin
                r_wk    <= (i_cmd.ack_upd && r_it.acked_seq >= r_last_next &&
                            33'(r_it.now_ticks) > 33'(r_stamps[r_head]) +
                            33'(r_period >> 2)) ? nxt(r_head) : r_head;
                r_wcnt  <= '0;
                r_wdone <= 1'b0;
                r_found <= 1'b0;
                r_best  <= '0;
            end
            if (i_cmd.walk_step) begin
                if (!r_live[r_wk]) begin
                    r_wdone <= 1'b1;
                end else if (expired) begin
                    r_live[r_wk] <= 1'b0;
                    r_wdone <= 1'b1;
                end else begin
                    if (!r_found || r_bins[r_wk] > r_best) r_best <= r_bins[r_wk];
                    r_found <= 1'b1;
                    r_wk    <= prv(r_wk);
                    r_wcnt  <= r_wcnt + 1'b1;
                    if (prv(r_wk) == r_head || 32'(r_wcnt) + 1 >= BINS) r_wdone <= 1'b1;
                end
            end
            if (i_cmd.ack_valid) begin
                r_pa_live <= r_found;
                r_pa      <= r_best;
                if (!(r_found && ((cwmss[63:33] != '0) ||
                      ({r_best, 1'b0} < cwmss[32:0])))) begin
                    r_valid  <= 1'b1;
                    r_vstamp <= r_it.now_ticks;
                    r_allow  <= 1'b1;
                end else begin
                    r_valid  <= 1'b0;
                    r_allow  <= r_it.cwnd_limited;
                end
            end
            if (i_cmd.cd_init) begin
                r_dnum <= diff - 32'd1;
                r_ddiv <= iv;
                r_drem <= '0;
                r_dq   <= '0;
                r_dcnt <= '0;
            end
            if (i_cmd.cwr_init) begin
                r_dnum <= (r_pa_live && r_it.mss != '0) ? r_pa : 32'd0;
                r_ddiv <= (r_it.mss != '0) ? 32'(r_it.mss) : 32'd1;
                r_drem <= '0;
                r_dq   <= '0;
                r_dcnt <= '0;
            end
            if (i_cmd.div_step) begin
                r_dnum <= {r_dnum[30:0], 1'b0};
                r_dcnt <= r_dcnt + 6'd1;
                if (!dtrial[32]) begin
                    r_drem <= dtrial[31:0];
                    r_dq   <= {r_dq[30:0], 1'b1};
                end else begin
                    r_drem <= {r_drem[30:0], r_dnum[31]};
                    r_dq   <= {r_dq[30:0], 1'b0};
                end
            end
            if (i_cmd.cd_apply) begin
                r_vstamp <= r_vstamp + r_dq * iv;
                r_cdn    <= (r_dq > 32'(CLOSEDOWN_CAP)) ? CLOSEDOWN_CAP : r_dq[5:0];
            end
            if (i_cmd.cd_step) begin
                if (q_c > r_ss) r_ss <= q_c;
                r_cwnd <= h_c;
                r_cdn  <= r_cdn - 6'd1;
            end
            if (i_cmd.cwr_fin || i_cmd.loss) begin
                if (i_cmd.cwr_fin) begin
                    r_cwnd <= w;
                    r_ss   <= w;
                end
                r_last_ack  <= r_it.acked_seq;
                r_last_next <= r_it.next_seq;
                r_vstamp    <= r_it.now_ticks;
                r_valid     <= 1'b1;
                r_recov     <= 1'b0;
                r_period    <= period_of(r_it.srtt_ticks, r_min_period);
                r_head      <= '0;
                r_live      <= '0;
                r_pa_live   <= 1'b0;
            end
            if (i_cmd.slow_fin) begin
                r_recov <= 1'b1;
                r_cwnd  <= ((base >> 1) == '0) ? 32'd1 : base >> 1;
            end
            if (i_cmd.ssq) begin
                r_ss <= ((r_it.in_flight >> 1) > 32'd2) ? r_it.in_flight >> 1 : 32'd2;
            end
        end
        if (i_cmd.out_load) begin
            r_out.cwnd_out        <= r_cwnd;
            r_out.ssthresh_out    <= r_ss;
            r_out.pipeack_out     <= r_pa_live ? r_pa : 32'd0;
            r_out.pipeack_defined <= r_pa_live;
            r_out.validated       <= r_valid;
            r_out.allow_increase  <= r_allow;
            r_out.in_recovery     <= r_recov;
        end
    end

endmodule

FILE: tb/tcp_cwnd_validation_engine_tb.sv
// Testbench for the cwnd validation engine: predicts each result and checks it.
`timescale 1ns / 100ps

class cwv_scoreboard;
    bit [31:0] min_period, cd_interval, init_cwnd, restart_win;
    bit [31:0] bin_val[4];
    bit        bin_live[4];
    bit [31:0] bin_stamp[4];
    bit [1:0]  head;
    bit [31:0] pipeack;
    bit        pa_live, valid_f, recov_f;
    bit [31:0] last_acked, last_next, vstamp, period, prior_infl, prior_retr;
    tcv_pkg::t_out pending[$];
    int errors;

    function void init();
        min_period = 1000; cd_interval = 75000000; init_cwnd = 10; restart_win = 1;
        foreach (bin_val[i]) begin
            bin_val[i] = 0; bin_live[i] = 0; bin_stamp[i] = 0;
        end
        head = 0; pipeack = 0; pa_live = 0; valid_f = 1; recov_f = 0;
        last_acked = 0; last_next = 0; vstamp = 0; period = 1000;
        prior_infl = 0; prior_retr = 0; errors = 0;
    endfunction

    function void set_reg(bit [1:0] idx, bit [31:0] d);
        case (idx)
            tcv_pkg::REG_MIN_PERIOD: min_period = d[15:0];
            tcv_pkg::REG_CLOSEDOWN:  cd_interval = d;
            tcv_pkg::REG_INIT_CWND:  init_cwnd = d[15:0];
            default:                 restart_win = d[15:0];
        endcase
    endfunction

    function bit [31:0] period_of(bit [31:0] srtt);
        bit [33:0] p;
        p = 3 * {2'b0, srtt};
        if (p > 34'hFFFF_FFFF) p = 34'hFFFF_FFFF;
        if (p < min_period) p = min_period;
        return p[31:0];
    endfunction

    function void restart(tcv_pkg::t_in x);
        last_acked = x.acked_seq; last_next = x.next_seq; vstamp = x.now_ticks;
        valid_f = 1; recov_f = 0; period = period_of(x.srtt_ticks); head = 0;
        foreach (bin_live[i]) bin_live[i] = 0;
        pa_live = 0; pipeack = 0;
    endfunction

    function void shrink(bit [31:0] now, ref bit [31:0] cw, ref bit [31:0] ss);
        bit [31:0] iv, diff, n, steps, q, h;
        bit [63:0] adv;
        iv = cd_interval != 0 ? cd_interval : 1;
        diff = now - vstamp;
        if (diff <= iv) return;
        n = (diff - 1) / iv;
        adv = n * {32'b0, iv};
        vstamp = vstamp + adv[31:0];
        steps = n > 40 ? 40 : n;
        for (int i = 0; i < steps; i++) begin
            q = ({2'b0, cw} * 3) >> 2;
            h = cw >> 1;
            if (q > ss) ss = q;
            cw = h > init_cwnd ? h : init_cwnd;
        end
    endfunction

    function void walk(bit [31:0] now);
        bit [1:0] k;
        bit [31:0] best;
        bit found;
        k = head; best = 0; found = 0;
        for (int i = 0; i < 4; i++) begin
            if (!bin_live[k]) break;
            if (now >= period && bin_stamp[k] < now - period) begin
                bin_live[k] = 0;
                break;
            end
            if (!found || bin_val[k] > best) begin
                best = bin_val[k]; found = 1;
            end
            k = k - 1;
            if (k == head) break;
        end
        pa_live = found;
        pipeack = found ? best : 0;
    endfunction

    function bit [31:0] recov_base(bit [15:0] mss);
        bit [31:0] q;
        q = (pa_live && mss != 0) ? pipeack / mss : 0;
        return q > prior_infl ? q : prior_infl;
    endfunction

    function void note_event(tcv_pkg::t_in x);
        tcv_pkg::t_out r;
        bit [31:0] cw, ss, smp, base, gone, w;
        bit allow;
        cw = x.cwnd_in; ss = x.ssthresh_in; allow = 0;
        case (x.operation)
            tcv_pkg::OP_ACK: begin
                prior_infl = x.in_flight; prior_retr = x.retx_count;
                period = period_of(x.srtt_ticks);
                if (x.acked_seq >= last_next) begin
                    smp = x.acked_seq - last_acked;
                    last_acked = x.acked_seq; last_next = x.next_seq;
                    if ({32'b0, x.now_ticks} >
                            {32'b0, bin_stamp[head]} + (period >> 2)) begin
                        head = head + 1;
                        bin_val[head] = smp; bin_live[head] = 1;
                        bin_stamp[head] = x.now_ticks;
                    end else if (!bin_live[head] || smp > bin_val[head]) begin
                        bin_val[head] = smp; bin_live[head] = 1;
                    end
                end
                walk(x.now_ticks);
                if (!pa_live || {pipeack, 1'b0} >= {16'b0, cw} * x.mss) begin
                    valid_f = 1; vstamp = x.now_ticks;
                end else begin
                    valid_f = 0;
                    shrink(x.now_ticks, cw, ss);
                end
                allow = valid_f || x.cwnd_limited;
            end
            tcv_pkg::OP_TX_START: shrink(x.now_ticks, cw, ss);
            tcv_pkg::OP_CWR: if (!valid_f) begin
                base = recov_base(x.mss);
                gone = x.retx_count - prior_retr;
                w = (base > gone ? base - gone : 0) >> 1;
                if (w < restart_win) w = restart_win;
                cw = w; ss = w;
                restart(x);
            end
            tcv_pkg::OP_LOSS: restart(x);
            tcv_pkg::OP_SLOW_ACK: if (!valid_f && !recov_f) begin
                recov_f = 1;
                cw = recov_base(x.mss) >> 1;
                if (cw < 1) cw = 1;
            end
            tcv_pkg::OP_SS_QUERY: ss = (x.in_flight >> 1) > 2 ? x.in_flight >> 1 : 2;
            default: ;
        endcase
        r.cwnd_out = cw; r.ssthresh_out = ss;
        r.pipeack_out = pa_live ? pipeack : 0;
        r.pipeack_defined = pa_live; r.validated = valid_f;
        r.allow_increase = allow; r.in_recovery = recov_f;
        pending.push_back(r);
    endfunction

    function void check_result(tcv_pkg::t_out a);
        tcv_pkg::t_out e;
        if (pending.size() == 0) begin
            $error("unexpected result transaction");
            errors++;
            return;
        end
        e = pending.pop_front();
        if (a.cwnd_out !== e.cwnd_out) begin
            $error("cwnd_out exp %0d got %0d", e.cwnd_out, a.cwnd_out); errors++;
        end
        if (a.ssthresh_out !== e.ssthresh_out) begin
            $error("ssthresh_out exp %0d got %0d", e.ssthresh_out, a.ssthresh_out); errors++;
        end
        if (a.pipeack_out !== e.pipeack_out) begin
            $error("pipeack_out exp %0d got %0d", e.pipeack_out, a.pipeack_out); errors++;
        end
        if (a.pipeack_defined !== e.pipeack_defined) begin
            $error("pipeack_defined exp %0b got %0b", e.pipeack_defined,
                   a.pipeack_defined); errors++;
        end
        if (a.validated !== e.validated) begin
            $error("validated exp %0b got %0b", e.validated, a.validated); errors++;
        end
        if (a.allow_increase !== e.allow_increase) begin
            $error("allow_increase exp %0b got %0b", e.allow_increase,
                   a.allow_increase); errors++;
        end
        if (a.in_recovery !== e.in_recovery) begin
            $error("in_recovery exp %0b got %0b", e.in_recovery, a.in_recovery); errors++;
        end
    endfunction
endclass

module tcp_cwnd_validation_engine_tb;
    import tcv_pkg::*;

    logic        clk, rst_n;
    logic        in_valid, in_stall, out_valid, out_stall;
    t_in         in_data;
    t_out        out_data;
    logic        cfg_valid, cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    cwv_scoreboard sb;
    int unsigned cycles;
    bit          hold_rx;
    bit [31:0]   now_t, seq_t;

    tcp_cwnd_validation_engine u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    initial begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > 2000000) begin
                $display("tcp_cwnd_validation_engine_tb: FAIL");
                $finish;
            end
        end
    end

    // receiver: random stall per transaction, optional long hold-off
    initial begin
        int unsigned gap;
        out_stall = 1;
        @(posedge clk iff rst_n);
        forever begin
            if (hold_rx) begin
                out_stall <= 1;
                repeat (300) @(posedge clk);
                hold_rx = 0;
            end
            gap = $urandom_range(3) == 0 ? 0 : $urandom_range(14);
            if (gap != 0) begin
                out_stall <= 1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            sb.check_result(out_data);
        end
    end

    task automatic write_reg(bit [1:0] idx, bit [31:0] d);
        cfg_valid <= 1; cfg_index <= idx; cfg_data <= d;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_reg(idx, d);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    task automatic send_event(t_in x, bit nogap);
        int unsigned gap;
        gap = nogap ? 0 : ($urandom_range(3) == 0 ? 0 : $urandom_range(14));
        if (gap != 0) begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1; in_data <= x;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_event(x);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    function automatic t_in rand_event(bit wild);
        t_in x;
        x.operation = wild ? 3'($urandom_range(7))
                           : ($urandom_range(9) < 6 ? OP_ACK : 3'($urandom_range(5)));
        x.cwnd_limited = 1'($urandom_range(1));
        if (wild) begin
            x.now_ticks = $urandom; x.acked_seq = $urandom; x.next_seq = $urandom;
            x.srtt_ticks = $urandom; x.cwnd_in = $urandom; x.ssthresh_in = $urandom;
            x.mss = 16'($urandom); x.in_flight = $urandom; x.retx_count = $urandom;
        end else begin
            now_t += $urandom_range(3000);
            x.now_ticks = now_t;
            x.acked_seq = seq_t + $urandom_range(20000);
            seq_t = x.acked_seq;
            x.next_seq = seq_t + $urandom_range(30000);
            x.srtt_ticks = $urandom_range(2000);
            x.cwnd_in = $urandom_range(200);
            x.ssthresh_in = $urandom_range(300);
            x.mss = $urandom_range(3) == 0 ? 16'd0 : 16'($urandom_range(1460, 100));
            x.in_flight = $urandom_range(400);
            x.retx_count = $urandom_range(50);
        end
        return x;
    endfunction

    initial begin
        t_in x;
        sb = new();
        sb.init();
        hold_rx = 0;
        now_t = 0; seq_t = 0;
        rst_n = 0; in_valid = 0; in_data = '0;
        cfg_valid = 0; cfg_index = REG_MIN_PERIOD; cfg_data = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: every operation and field extremes
        for (int op = 0; op < 8; op++) begin
            x = rand_event(0);
            x.operation = 3'(op);
            send_event(x, 0);
        end
        x = '1;
        x.operation = OP_ACK;
        send_event(x, 0);
        x.operation = OP_SS_QUERY;
        send_event(x, 0);
        x = '0;
        send_event(x, 0);
        x.operation = OP_SS_QUERY;
        send_event(x, 0);
        x.operation = OP_LOSS;
        send_event(x, 0);
        drain();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    write_reg(REG_MIN_PERIOD, 1); write_reg(REG_CLOSEDOWN, 1);
                    write_reg(REG_INIT_CWND, 1); write_reg(REG_RESTART, 1);
                end
                1: begin
                    write_reg(REG_MIN_PERIOD, 65535); write_reg(REG_CLOSEDOWN, 32'hFFFF_FFFF);
                    write_reg(REG_INIT_CWND, 65535); write_reg(REG_RESTART, 65535);
                end
                2: begin
                    write_reg(REG_MIN_PERIOD, 2000); write_reg(REG_CLOSEDOWN, 500);
                    write_reg(REG_INIT_CWND, 4); write_reg(REG_RESTART, 2);
                end
                3: begin
                    write_reg(REG_CLOSEDOWN, 0);
                    write_reg(REG_MIN_PERIOD, $urandom_range(65535, 1));
                end
                default: begin
                    write_reg(REG_MIN_PERIOD, 1000); write_reg(REG_CLOSEDOWN, 7000);
                    write_reg(REG_INIT_CWND, 10); write_reg(REG_RESTART, 1);
                end
            endcase
            if (phase == 2) hold_rx = 1;
            for (int i = 0; i < 100; i++) begin
                x = rand_event($urandom_range(9) == 0);
                send_event(x, phase == 2 && i < 30);
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tcp_cwnd_validation_engine_tb: PASS");
        else
            $display("tcp_cwnd_validation_engine_tb: FAIL");
        $finish;
    end
endmodule
